>>> src/ptd_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the point to triangle distance block.
// No dependencies; used by the channel interfaces and the top level.
package ptd_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int DIST_W          = 32;
    localparam int QUO_W           = 2 * DIST_W;
    localparam int ROOT_W          = DIST_W;
    localparam int NUM_EDGES       = 3;
    localparam int NUM_LANES       = NUM_EDGES + 1;
    localparam int PLANE_LANE      = NUM_EDGES;

    // cyclic successor and predecessor of an axis or a vertex
    localparam int NEXT_IDX [3] = '{1, 2, 0};
    localparam int PREV_IDX [3] = '{2, 0, 1};

endpackage

>>> src/ptd_in_if.sv
`timescale 1ns / 1ps
// Input channel: query point and three triangle vertices.
// Depends on ptd_pkg for the default coordinate width.
interface ptd_in_if #(parameter int W = ptd_pkg::COORD_WIDTH_DEF);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;
    logic signed [W-1:0] point_z;
    logic signed [W-1:0] vert_a_x;
    logic signed [W-1:0] vert_a_y;
    logic signed [W-1:0] vert_a_z;
    logic signed [W-1:0] vert_b_x;
    logic signed [W-1:0] vert_b_y;
    logic signed [W-1:0] vert_b_z;
    logic signed [W-1:0] vert_c_x;
    logic signed [W-1:0] vert_c_y;
    logic signed [W-1:0] vert_c_z;

    modport source (output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
                    vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
                    input ready);
    modport sink   (input valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
                    vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
                    output ready);
endinterface

>>> src/ptd_out_if.sv
`timescale 1ns / 1ps
// Output channel: distance and status flags.
// Depends on ptd_pkg for the distance width.
interface ptd_out_if;
    logic                        valid;
    logic                        ready;
    logic [ptd_pkg::DIST_W-1:0]  dist_res;
    logic                        outside_edge;
    logic                        degenerate;
    logic                        saturated;

    modport source (output valid, dist_res, outside_edge, degenerate, saturated, input ready);
    modport sink   (input valid, dist_res, outside_edge, degenerate, saturated, output ready);
endinterface

>>> src/point_triangle_distance.sv
`timescale 1ns / 1ps
// Point to triangle distance, fully pipelined top level.
// Depends on ptd_pkg, ptd_in_if and ptd_out_if.
//
//  channel | dir | handshake     | payload
//  i_pt    | in  | valid / ready | point, vertex a, vertex b, vertex c (x, y, z)
//  o_res   | out | valid / ready | dist_res, outside_edge, degenerate, saturated
//
// One item enters per cycle unless the pipeline is frozen; each item passes through
// 6 setup stages (differences, crosses, limb products, dot sums, operand select,
// plane square), a 65 stage restoring divider with four lanes, one select stage
// and a 32 stage root.
// Reset is synchronous and clears only the valid bits.
// When the output is held and not taken, the whole pipeline freezes; i_pt.ready drops.
module point_triangle_distance #(
    parameter int COORD_WIDTH = ptd_pkg::COORD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptd_in_if.sink      i_pt,
    ptd_out_if.source   o_res
);

    localparam int DW    = COORD_WIDTH + 1;
    localparam int PW    = 2 * DW + 2;
    localparam int CW    = 2 * DW + 1;
    localparam int TW    = 2 * CW + 2;
    localparam int NDW   = CW + DW + 2;
    localparam int NUM_W = 2 * NDW;
    localparam int DEN_W = TW;
    localparam int QW    = ptd_pkg::QUO_W;
    localparam int RW    = ptd_pkg::ROOT_W;
    localparam int CMPW  = NUM_W + QW + 1;
    localparam int SQW   = QW + 2;
    localparam int NE    = ptd_pkg::NUM_EDGES;
    localparam int NL    = ptd_pkg::NUM_LANES;
    localparam int LB    = (CW + 1) / 2;
    localparam int PPW   = 2 * LB + 5;
    localparam int LB2   = (NDW + 2) / 3;
    localparam int QPW   = 2 * LB2 + 4;
    localparam int NQ    = 5;
    localparam int NSTG  = 6 + (QW + 1) + 1 + RW;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QW-1:0]    q;
        logic             cap;
    } t_lane;

    typedef struct packed {
        logic [NE-1:0] fail;
        logic          degen;
    } t_side;

    typedef struct packed {
        logic [QW-1:0]  v;
        logic [RW-1:0]  r;
        logic [QW-1:0]  sq;
        logic           sat;
        logic           outside;
        logic           degen;
    } t_root;

    // dot product kept as three sums of limb products, weights 2^(2LB), 2^LB, 1
    typedef struct packed {
        logic [PPW-1:0] hh;
        logic [PPW-1:0] mid;
        logic [PPW-1:0] ll;
    } t_dot;

    function automatic logic signed [LB:0] limb_hi(logic signed [CW-1:0] a);
        return (LB + 1)'(a >>> LB);
    endfunction

    function automatic logic signed [LB:0] limb_lo(logic signed [CW-1:0] a);
        return $signed({1'b0, a[LB-1:0]});
    endfunction

    function automatic t_dot dot_split(logic signed [CW-1:0] a [3],
                                       logic signed [CW-1:0] b [3]);
        t_dot               r;
        logic signed [LB:0] ah;
        logic signed [LB:0] al;
        logic signed [LB:0] bh;
        logic signed [LB:0] bl;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            ah = limb_hi(a[i]);
            al = limb_lo(a[i]);
            bh = limb_hi(b[i]);
            bl = limb_lo(b[i]);
            r.hh  = r.hh + PPW'(ah) * PPW'(bh);
            r.mid = r.mid + PPW'(ah) * PPW'(bl) + PPW'(al) * PPW'(bh);
            r.ll  = r.ll + PPW'(al) * PPW'(bl);
        end
        return r;
    endfunction

    function automatic logic signed [TW-1:0] dot_join(t_dot p);
        return (TW'($signed(p.hh)) <<< (2 * LB)) + (TW'($signed(p.mid)) <<< LB)
             + TW'($signed(p.ll));
    endfunction

    logic            en;
    logic [NSTG-1:0] r_vld;

    assign en         = !r_vld[NSTG-1] || o_res.ready;
    assign i_pt.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_pt.valid};
        end
    end

    // ---------------- stage 1: edge and offset vectors
    logic signed [COORD_WIDTH-1:0] w_p [3];
    logic signed [COORD_WIDTH-1:0] w_v [3][3];
    logic signed [DW-1:0] r1_e [3][3];
    logic signed [DW-1:0] r1_d [3][3];
    logic signed [DW-1:0] r1_f [3];

    always_comb begin
        w_p[0]    = i_pt.point_x;  w_p[1]    = i_pt.point_y;  w_p[2]    = i_pt.point_z;
        w_v[0][0] = i_pt.vert_a_x; w_v[0][1] = i_pt.vert_a_y; w_v[0][2] = i_pt.vert_a_z;
        w_v[1][0] = i_pt.vert_b_x; w_v[1][1] = i_pt.vert_b_y; w_v[1][2] = i_pt.vert_b_z;
        w_v[2][0] = i_pt.vert_c_x; w_v[2][1] = i_pt.vert_c_y; w_v[2][2] = i_pt.vert_c_z;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r1_e[k][i] <= DW'(w_v[ptd_pkg::NEXT_IDX[k]][i]) - DW'(w_v[k][i]);
                    r1_d[k][i] <= DW'(w_p[i]) - DW'(w_v[k][i]);
                end
            end
            for (int i = 0; i < 3; i++) begin
                r1_f[i] <= DW'(w_v[2][i]) - DW'(w_v[0][i]);
            end
        end
    end

    // ---------------- stage 2: normal, edge crosses, narrow dots
    logic signed [CW-1:0] r2_n [3];
    logic signed [CW-1:0] r2_x [3][3];
    logic signed [PW-1:0] r2_s [3];
    logic signed [PW-1:0] r2_ee [3];
    logic signed [PW-1:0] r2_dd [3];
    logic signed [DW-1:0] r2_d0 [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r2_n[i] <= CW'(r1_e[0][ptd_pkg::NEXT_IDX[i]]) * CW'(r1_f[ptd_pkg::PREV_IDX[i]])
                         - CW'(r1_e[0][ptd_pkg::PREV_IDX[i]]) * CW'(r1_f[ptd_pkg::NEXT_IDX[i]]);
                r2_d0[i] <= r1_d[0][i];
            end
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r2_x[k][i] <=
                        CW'(r1_e[k][ptd_pkg::NEXT_IDX[i]]) * CW'(r1_d[k][ptd_pkg::PREV_IDX[i]])
                      - CW'(r1_e[k][ptd_pkg::PREV_IDX[i]]) * CW'(r1_d[k][ptd_pkg::NEXT_IDX[i]]);
                end
                r2_s[k]  <= PW'(r1_d[k][0]) * PW'(r1_e[k][0]) + PW'(r1_d[k][1]) * PW'(r1_e[k][1])
                          + PW'(r1_d[k][2]) * PW'(r1_e[k][2]);
                r2_ee[k] <= PW'(r1_e[k][0]) * PW'(r1_e[k][0]) + PW'(r1_e[k][1]) * PW'(r1_e[k][1])
                          + PW'(r1_e[k][2]) * PW'(r1_e[k][2]);
                r2_dd[k] <= PW'(r1_d[k][0]) * PW'(r1_d[k][0]) + PW'(r1_d[k][1]) * PW'(r1_d[k][1])
                          + PW'(r1_d[k][2]) * PW'(r1_d[k][2]);
            end
        end
    end

    // ---------------- stage 3a: limb products of the wide dots
    logic signed [CW-1:0] w_d0 [3];
    t_dot                 r3p_test [3];
    t_dot                 r3p_xx [3];
    t_dot                 r3p_nn;
    t_dot                 r3p_nd;
    logic signed [PW-1:0] r3p_s [3];
    logic signed [PW-1:0] r3p_ee [3];
    logic signed [PW-1:0] r3p_dd [3];
    logic                 r3p_degen;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d0[i] = CW'(r2_d0[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r3p_test[k] <= dot_split(r2_n, r2_x[k]);
                r3p_xx[k]   <= dot_split(r2_x[k], r2_x[k]);
                r3p_s[k]    <= r2_s[k];
                r3p_ee[k]   <= r2_ee[k];
                r3p_dd[k]   <= r2_dd[k];
            end
            r3p_nn    <= dot_split(r2_n, r2_n);
            r3p_nd    <= dot_split(r2_n, w_d0);
            r3p_degen <= (r2_n[0] == 0) && (r2_n[1] == 0) && (r2_n[2] == 0);
        end
    end

    // ---------------- stage 3b: edge tests, wide dots, clamp conditions
    logic                  r3_neg [3];
    logic signed [TW-1:0]  r3_xx [3];
    logic signed [TW-1:0]  r3_nn;
    logic signed [NDW-1:0] r3_nd;
    logic                  r3_lo [3];
    logic                  r3_hi [3];
    logic signed [PW-1:0]  r3_dd [3];
    logic signed [PW-1:0]  r3_ee [3];
    logic                  r3_degen;
    logic signed [TW-1:0]  w3_test [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w3_test[k] = dot_join(r3p_test[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r3_neg[k] <= w3_test[k][TW-1];
                r3_xx[k]  <= dot_join(r3p_xx[k]);
                r3_lo[k]  <= (r3p_s[k] <= 0) || (r3p_ee[k] == 0);
                r3_hi[k]  <= r3p_s[k] >= r3p_ee[k];
                r3_dd[k]  <= r3p_dd[k];
                r3_ee[k]  <= r3p_ee[k];
            end
            r3_nn    <= dot_join(r3p_nn);
            r3_nd    <= NDW'(dot_join(r3p_nd));
            r3_degen <= r3p_degen;
        end
    end

    // ---------------- stage 4: pick edge operands, limb products of the plane square
    logic [NUM_W-1:0]      r4_num [NE];
    logic [DEN_W-1:0]      r4_den [NE];
    logic [QPW-1:0]        r4_q [NQ];
    logic [DEN_W-1:0]      r4_nn;
    t_side                 r4_side;
    logic signed [LB2:0]   w4_h;
    logic signed [LB2:0]   w4_m;
    logic signed [LB2:0]   w4_l;

    always_comb begin
        w4_h = (LB2 + 1)'(r3_nd >>> (2 * LB2));
        w4_m = $signed({1'b0, r3_nd[2*LB2-1:LB2]});
        w4_l = $signed({1'b0, r3_nd[LB2-1:0]});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NE; k++) begin
                if (r3_lo[k]) begin
                    r4_num[k] <= NUM_W'(r3_dd[k]);
                    r4_den[k] <= DEN_W'(1);
                end else if (r3_hi[k]) begin
                    // clamped at the far vertex: offset from the next vertex
                    r4_num[k] <= NUM_W'(r3_dd[ptd_pkg::NEXT_IDX[k]]);
                    r4_den[k] <= DEN_W'(1);
                end else begin
                    r4_num[k] <= NUM_W'(r3_xx[k]);
                    r4_den[k] <= DEN_W'(r3_ee[k]);
                end
                r4_side.fail[k] <= r3_neg[k];
            end
            r4_q[0] <= QPW'(w4_l) * QPW'(w4_l);
            r4_q[1] <= (QPW'(w4_l) * QPW'(w4_m)) <<< 1;
            r4_q[2] <= QPW'(w4_m) * QPW'(w4_m) + ((QPW'(w4_h) * QPW'(w4_l)) <<< 1);
            r4_q[3] <= (QPW'(w4_h) * QPW'(w4_m)) <<< 1;
            r4_q[4] <= QPW'(w4_h) * QPW'(w4_h);
            r4_nn         <= r3_nn;
            r4_side.degen <= r3_degen;
        end
    end

    // ---------------- stage 5: sum the plane square, hold the edge lanes
    logic [NUM_W-1:0] r5_num [NL];
    logic [DEN_W-1:0] r5_den [NL];
    t_side            r5_side;
    logic [NUM_W-1:0] w5_sq;

    always_comb begin
        w5_sq = '0;
        for (int i = 0; i < NQ; i++) begin
            w5_sq = w5_sq + (NUM_W'($signed(r4_q[i])) <<< (i * LB2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NE; k++) begin
                r5_num[k] <= r4_num[k];
                r5_den[k] <= r4_den[k];
            end
            if (r4_side.degen) begin
                r5_num[ptd_pkg::PLANE_LANE] <= '0;
                r5_den[ptd_pkg::PLANE_LANE] <= DEN_W'(1);
            end else begin
                r5_num[ptd_pkg::PLANE_LANE] <= w5_sq;
                r5_den[ptd_pkg::PLANE_LANE] <= r4_nn;
            end
            r5_side <= r4_side;
        end
    end

    // ---------------- divider: floor(num / den), capped at 2^QW
    t_lane r_dv   [0:QW][NL];
    t_side r_dside [0:QW];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < NL; l++) begin
                r_dv[0][l].rem <= r5_num[l];
                r_dv[0][l].den <= r5_den[l];
                r_dv[0][l].q   <= '0;
                r_dv[0][l].cap <= CMPW'(r5_num[l]) >= (CMPW'(r5_den[l]) << QW);
            end
            r_dside[0] <= r5_side;
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_div
        localparam int B = QW - j;
        for (genvar l = 0; l < NL; l++) begin : g_lane
            logic [CMPW-1:0] w_trial;
            t_lane           w_next;
            always_comb begin
                w_trial = CMPW'(r_dv[j-1][l].den) << B;
                w_next  = r_dv[j-1][l];
                if (CMPW'(r_dv[j-1][l].rem) >= w_trial) begin
                    w_next.rem  = r_dv[j-1][l].rem - w_trial[NUM_W-1:0];
                    w_next.q[B] = 1'b1;
                end
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv[j][l] <= w_next;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dside[j] <= r_dside[j-1];
            end
        end
    end

    // ---------------- select: least failing edge, else the plane
    logic [QW:0] w_val [NL];
    logic [QW:0] w_best;
    logic        w_any;
    t_root       r_rt [0:RW];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            w_val[l] = r_dv[QW][l].cap ? {1'b1, QW'(0)} : {1'b0, r_dv[QW][l].q};
        end
        w_any  = |r_dside[QW].fail;
        w_best = {1'b1, QW'(0)};
        for (int k = 0; k < NE; k++) begin
            if (r_dside[QW].fail[k] && (w_val[k] < w_best)) begin
                w_best = w_val[k];
            end
        end
        if (!w_any) begin
            w_best = w_val[ptd_pkg::PLANE_LANE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rt[0].sat     <= w_best[QW] && !r_dside[QW].degen;
            r_rt[0].v       <= (w_best[QW] || r_dside[QW].degen) ? '0 : w_best[QW-1:0];
            r_rt[0].r       <= '0;
            r_rt[0].sq      <= '0;
            r_rt[0].outside <= w_any && !r_dside[QW].degen;
            r_rt[0].degen   <= r_dside[QW].degen;
        end
    end

    // ---------------- integer root, one result bit per stage
    for (genvar j = 1; j <= RW; j++) begin : g_root
        localparam int B = RW - j;
        logic [SQW-1:0] w_trial;
        t_root          w_next;
        always_comb begin
            w_trial = SQW'(r_rt[j-1].sq) + (SQW'(r_rt[j-1].r) << (B + 1))
                    + (SQW'(1) << (2 * B));
            w_next  = r_rt[j-1];
            if (w_trial <= SQW'(r_rt[j-1].v)) begin
                w_next.r[B] = 1'b1;
                w_next.sq   = w_trial[QW-1:0];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rt[j] <= w_next;
            end
        end
    end

    assign o_res.valid        = r_vld[NSTG-1];
    assign o_res.dist_res     = r_rt[RW].sat ? '1 : r_rt[RW].r;
    assign o_res.outside_edge = r_rt[RW].outside;
    assign o_res.degenerate   = r_rt[RW].degen;
    assign o_res.saturated    = r_rt[RW].sat;

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pt.valid && i_pt.ready |=> r_vld[0])
        else $error("accepted item did not enter the pipeline");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.degenerate |->
            (o_res.dist_res == 0) && !o_res.outside_edge && !o_res.saturated)
        else $error("degenerate triangle gave a nonzero result");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.saturated |-> (o_res.dist_res == '1) && !o_res.degenerate)
        else $error("saturated result not clamped");

endmodule
